// File: src/gcl_pkg.sv
// ----------------------------------------------------------------------------
// gcl_pkg
// Shared types, codes, reset values and saturating arithmetic for the
// write credit limiter with its per-channel pressure state.
// ----------------------------------------------------------------------------
package gcl_pkg;

  // Number of flash channels held in the channel state memory.
  localparam int CHANNELS = 16;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Transaction command codes.
  localparam logic [3:0] CMD_LINE_FREED   = 4'd0;
  localparam logic [3:0] CMD_TAKEN_USED   = 4'd1;
  localparam logic [3:0] CMD_TAKEN_UNUSED = 4'd2;
  localparam logic [3:0] CMD_USER_IN      = 4'd3;
  localparam logic [3:0] CMD_GC_IN        = 4'd4;
  localparam logic [3:0] CMD_DRAINED      = 4'd5;
  localparam logic [3:0] CMD_USER_QUERY   = 4'd6;
  localparam logic [3:0] CMD_GC_QUERY     = 4'd7;
  localparam logic [3:0] CMD_RESERVE      = 4'd8;
  localparam logic [3:0] CMD_TICK         = 4'd9;
  localparam logic [3:0] CMD_CHAN_LOAD    = 4'd10;

  // Channel pressure levels.
  localparam logic [1:0] PR_HIGH = 2'd0;
  localparam logic [1:0] PR_MID  = 2'd1;
  localparam logic [1:0] PR_LOW  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CHAN_SHARE     = 3'd0;
  localparam logic [2:0] CFG_USER_BUDGET    = 3'd1;
  localparam logic [2:0] CFG_RESERVE_MARK   = 3'd2;
  localparam logic [2:0] CFG_MID_MARK       = 3'd3;
  localparam logic [2:0] CFG_HIGH_MARK      = 3'd4;
  localparam logic [2:0] CFG_VERY_HIGH_MARK = 3'd5;
  localparam logic [2:0] CFG_ACTIVE_TIMEOUT = 3'd6;

  // Register values after reset.
  localparam logic [13:0] CHAN_SHARE_RST     = 14'd64;
  localparam logic [15:0] USER_BUDGET_RST    = 16'd1024;
  localparam logic [15:0] RESERVE_MARK_RST   = 16'd8;
  localparam logic [15:0] MID_MARK_RST       = 16'd24;
  localparam logic [15:0] HIGH_MARK_RST      = 16'd48;
  localparam logic [15:0] VERY_HIGH_MARK_RST = 16'd64;
  localparam logic [15:0] ACTIVE_TIMEOUT_RST = 16'd5000;

  typedef struct packed {
    logic [3:0]  command;
    logic [3:0]  channel;
    logic [15:0] line_blocks;
    logic [31:0] line_sectors;
    logic [15:0] user_entries;
    logic [15:0] gc_entries;
    logic [31:0] sectors_needed;
    logic        gc_stopped;
  } in_item_t;

  typedef struct packed {
    logic        allowed;
    logic [1:0]  pressure_state;
    logic        gc_start;
    logic        gc_stop;
    logic [15:0] user_limit;
    logic [15:0] free_user_count;
  } out_item_t;

  // One entry of the channel state memory.
  typedef struct packed {
    logic [1:0]  pressure;
    logic [15:0] gc_share;
    logic [15:0] free_total;
    logic [15:0] free_user;
    logic [31:0] sector_budget;
  } chan_entry_t;

  localparam chan_entry_t CHAN_ENTRY_RST = '{
    pressure: PR_HIGH, gc_share: 16'd0, free_total: 16'd0,
    free_user: 16'd0, sector_budget: 32'd0
  };

  // Global buffer occupancy and user activity.
  typedef struct packed {
    logic [15:0] user_occ;
    logic [15:0] gc_occ;
    logic [15:0] user_cap;
    logic        user_active;
    logic [15:0] idle_ticks;
  } glob_t;

  // Configuration that the update logic reads.
  typedef struct packed {
    logic [13:0] chan_share;
    logic [15:0] reserve_mark;
    logic [15:0] mid_mark;
    logic [15:0] high_mark;
    logic [15:0] very_high_mark;
    logic [15:0] active_timeout;
  } cfg_t;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [15:0] sat_sub16(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? (a - b) : 16'd0;
  endfunction

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// File: src/gcl_chan_store.sv
// ----------------------------------------------------------------------------
// gcl_chan_store
// Channel state memory with a registered read port, one write port and a
// valid bit per channel so that unwritten entries read as their reset value.
// ----------------------------------------------------------------------------
module gcl_chan_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [gcl_pkg::CH_IDX_W-1:0]  rd_addr,
  output gcl_pkg::chan_entry_t          rd_entry,
  input  logic                          wr_en,
  input  logic [gcl_pkg::CH_IDX_W-1:0]  wr_addr,
  input  gcl_pkg::chan_entry_t          wr_entry
);
  import gcl_pkg::*;

  chan_entry_t           mem [CHANNELS];
  logic [CHANNELS-1:0]   valid_r;
  chan_entry_t           rd_data_r;
  logic                  rd_valid_r;

  // Storage array, written back after each channel update.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // Valid bits are cleared together by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read; the valid flag travels with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else if (rd_en) begin
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_entry = rd_valid_r ? rd_data_r : CHAN_ENTRY_RST;

endmodule

// File: src/gcl_step_logic.sv
// ----------------------------------------------------------------------------
// gcl_step_logic
// Modify stage: applies one transaction to the channel entry read from the
// memory and to the global counters, including the watermark hysteresis.
// ----------------------------------------------------------------------------
module gcl_step_logic (
  input  gcl_pkg::in_item_t     item,
  input  logic                  chan_ok,
  input  gcl_pkg::chan_entry_t  entry,
  input  gcl_pkg::glob_t        glob,
  input  gcl_pkg::cfg_t         cfg,
  output gcl_pkg::chan_entry_t  entry_nxt,
  output gcl_pkg::glob_t        glob_nxt,
  output gcl_pkg::out_item_t    result
);
  import gcl_pkg::*;

  chan_entry_t  e;
  glob_t        g;
  logic         allowed;
  logic         start;
  logic         stop;
  logic         do_rate;
  logic [15:0]  share16;
  logic [15:0]  share2;
  logic [15:0]  idle_inc;
  logic [15:0]  f;

  assign share16  = {2'b00, cfg.chan_share};
  assign share2   = {1'b0, cfg.chan_share, 1'b0};
  assign idle_inc = sat_add16(glob.idle_ticks, 16'd1);

  always_comb begin
    e       = entry;
    g       = glob;
    allowed = 1'b0;
    start   = 1'b0;
    stop    = 1'b0;
    do_rate = 1'b0;
    f       = 16'd0;

    // Command decode and field updates.
    unique case (item.command)
      CMD_LINE_FREED: begin
        if (chan_ok) begin
          e.free_total    = sat_add16(e.free_total, item.line_blocks);
          e.free_user     = sat_add16(e.free_user, item.line_blocks);
          e.sector_budget = sat_add32(e.sector_budget, item.line_sectors);
          do_rate         = 1'b1;
        end
      end
      CMD_TAKEN_USED, CMD_TAKEN_UNUSED: begin
        if (chan_ok) begin
          e.free_total = sat_sub16(e.free_total, item.line_blocks);
          if (item.command == CMD_TAKEN_USED) begin
            e.free_user = sat_sub16(e.free_user, item.line_blocks);
          end
          do_rate = 1'b1;
        end
      end
      CMD_USER_IN: begin
        g.user_occ    = sat_add16(g.user_occ, item.user_entries);
        g.user_active = 1'b1;
        g.idle_ticks  = 16'd0;
      end
      CMD_GC_IN: begin
        g.gc_occ = sat_add16(g.gc_occ, item.gc_entries);
      end
      CMD_DRAINED: begin
        g.user_occ = sat_sub16(g.user_occ, item.user_entries);
        g.gc_occ   = sat_sub16(g.gc_occ, item.gc_entries);
      end
      CMD_USER_QUERY: begin
        allowed = item.gc_stopped || (g.user_occ < g.user_cap);
      end
      CMD_GC_QUERY: begin
        if (chan_ok) begin
          allowed = !((g.gc_occ >= e.gc_share) && g.user_active);
        end
      end
      CMD_RESERVE: begin
        if (chan_ok && (e.sector_budget >= item.sectors_needed)) begin
          e.sector_budget = e.sector_budget - item.sectors_needed;
          allowed         = 1'b1;
        end
      end
      CMD_TICK: begin
        if (g.user_active) begin
          if (idle_inc >= cfg.active_timeout) begin
            g.user_active = 1'b0;
            g.idle_ticks  = 16'd0;
          end else begin
            g.idle_ticks = idle_inc;
          end
        end
      end
      CMD_CHAN_LOAD: begin
        if (chan_ok) begin
          e.free_total    = item.line_blocks;
          e.free_user     = item.line_blocks;
          e.sector_budget = item.line_sectors;
          e.pressure      = PR_HIGH;
          e.gc_share      = 16'd0;
        end
      end
      default: begin
      end
    endcase

    // Watermark hysteresis on the new free user block count.
    if (do_rate) begin
      f = e.free_user;
      unique case (e.pressure)
        PR_HIGH: begin
          if (f < cfg.high_mark) begin
            e.gc_share = share16;
            e.pressure = PR_MID;
            start      = 1'b1;
            if (f <= cfg.reserve_mark) begin
              g.user_cap = sat_sub16(g.user_cap, share2);
              e.gc_share = sat_add16(e.gc_share, share16);
              e.pressure = PR_LOW;
            end
          end
        end
        PR_MID: begin
          if (f > cfg.very_high_mark) begin
            e.gc_share = 16'd0;
            e.pressure = PR_HIGH;
            stop       = 1'b1;
          end else if (f <= cfg.reserve_mark) begin
            g.user_cap = sat_sub16(g.user_cap, share2);
            e.gc_share = sat_add16(e.gc_share, share16);
            e.pressure = PR_LOW;
          end
        end
        default: begin
          if (f > cfg.mid_mark) begin
            g.user_cap = sat_add16(g.user_cap, share2);
            e.gc_share = share16;
            e.pressure = PR_MID;
            if (f > cfg.very_high_mark) begin
              e.gc_share = 16'd0;
              e.pressure = PR_HIGH;
              stop       = 1'b1;
            end
          end
        end
      endcase
    end
  end

  assign entry_nxt = e;
  assign glob_nxt  = g;

  // Result transaction.
  assign result.allowed         = allowed;
  assign result.pressure_state  = chan_ok ? e.pressure : 2'd0;
  assign result.gc_start        = start;
  assign result.gc_stop         = stop;
  assign result.user_limit      = g.user_cap;
  assign result.free_user_count = chan_ok ? e.free_user : 16'd0;

endmodule

// File: src/gc_write_credit_limiter_unit.sv
// ----------------------------------------------------------------------------
// gc_write_credit_limiter_unit
// Write buffer credit limiter: per-channel watermark hysteresis, global
// buffer occupancy and admission queries, with a channel state memory.
// ----------------------------------------------------------------------------
// Timing: the accepting edge registers the transaction and reads the channel
// state memory; the result is registered when the update finishes.
// A new transaction is not taken until the read and write-back of the channel
// state memory finish; a stalled result holds the next.
// Reset: synchronous, active low; channel entries read as their reset value
// through per-channel valid bits, so there is no clearing pass.
module gc_write_credit_limiter_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gcl_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gcl_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import gcl_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                 state_r;
  logic                 state_nxt;
  in_item_t             item_r;
  cfg_t                 cfg_r;
  glob_t                glob_r;
  glob_t                glob_nxt;
  chan_entry_t          rd_entry;
  chan_entry_t          entry_nxt;
  out_item_t            result;
  out_item_t            out_data_r;
  logic                 out_valid_r;
  logic                 in_acc;
  logic                 finish;
  logic                 chan_ok;
  logic [CH_IDX_W-1:0]  rd_addr;
  logic [CH_IDX_W-1:0]  item_addr;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r == ST_EXEC);
  assign finish    = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);
  assign chan_ok   = (32'(item_r.channel) < CHANNELS);
  assign rd_addr   = CH_IDX_W'(in_data.channel);
  assign item_addr = CH_IDX_W'(item_r.channel);

  // Configuration registers; user_budget only sets user_cap at reset.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chan_share     <= CHAN_SHARE_RST;
      cfg_r.reserve_mark   <= RESERVE_MARK_RST;
      cfg_r.mid_mark       <= MID_MARK_RST;
      cfg_r.high_mark      <= HIGH_MARK_RST;
      cfg_r.very_high_mark <= VERY_HIGH_MARK_RST;
      cfg_r.active_timeout <= ACTIVE_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CHAN_SHARE:     cfg_r.chan_share     <= cfg_data[13:0];
        CFG_RESERVE_MARK:   cfg_r.reserve_mark   <= cfg_data;
        CFG_MID_MARK:       cfg_r.mid_mark       <= cfg_data;
        CFG_HIGH_MARK:      cfg_r.high_mark      <= cfg_data;
        CFG_VERY_HIGH_MARK: cfg_r.very_high_mark <= cfg_data;
        CFG_ACTIVE_TIMEOUT: cfg_r.active_timeout <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer: accept and read, then update and write back.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_EXEC;
      ST_EXEC: if (finish) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Accepted transaction payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
  end

  // Global counters and activity tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glob_r.user_occ    <= 16'd0;
      glob_r.gc_occ      <= 16'd0;
      glob_r.user_cap    <= USER_BUDGET_RST;
      glob_r.user_active <= 1'b0;
      glob_r.idle_ticks  <= 16'd0;
    end else if (finish) begin
      glob_r <= glob_nxt;
    end
  end

  gcl_chan_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .wr_en    (finish && chan_ok),
    .wr_addr  (item_addr),
    .wr_entry (entry_nxt)
  );

  gcl_step_logic u_step (
    .item      (item_r),
    .chan_ok   (chan_ok),
    .entry     (rd_entry),
    .glob      (glob_r),
    .cfg       (cfg_r),
    .entry_nxt (entry_nxt),
    .glob_nxt  (glob_nxt),
    .result    (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: src/gcl_checker.sv
// ----------------------------------------------------------------------------
// gcl_checker
// Port-level checks for the credit limiter, attached to the top level.
// ----------------------------------------------------------------------------
module gcl_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input gcl_pkg::out_item_t  out_data
);
  import gcl_pkg::*;

  // No result is presented right after a reset cycle.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // The channel memory read-modify-write blocks the next transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken during channel update");

  // Each accepted transaction gives a result once the output is free.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 (!out_valid || !out_stall) |=> out_valid)
    else $error("result missing after transaction");

  // GC start leaves high pressure; GC stop returns to it.
  a_gc_pulse_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.gc_start || (out_data.pressure_state != PR_HIGH)) &&
                  (!out_data.gc_stop || (out_data.pressure_state == PR_HIGH)))
    else $error("gc pulse does not match pressure state");

endmodule

bind gc_write_credit_limiter_unit gcl_checker u_gcl_checker (.*);
